// ===== rtl/battery_low_voltage_cutoff_defines.svh =====
// ----------------------------------------------------------------------------
// battery low voltage cutoff assertion macros
// shared property forms for the cutoff block checks
// ----------------------------------------------------------------------------
`ifndef BATTERY_LOW_VOLTAGE_CUTOFF_DEFINES_SVH
`define BATTERY_LOW_VOLTAGE_CUTOFF_DEFINES_SVH

// same-cycle implication
`define BCUT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BCUT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bcut_pkg.sv =====
// ----------------------------------------------------------------------------
// bcut_pkg
// types, register indexes and reset values of the battery cutoff block
// ----------------------------------------------------------------------------
package bcut_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_TRIP_LEVEL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEVEL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_SECONDS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 3'd4;

    localparam logic [7:0] TRIP_LEVEL_RST       = 8'd166;
    localparam logic [7:0] RELEASE_LEVEL_RST    = 8'd174;
    localparam logic [3:0] RETRY_LIMIT_RST      = 4'hA;
    localparam logic [7:0] TIMEOUT_SECONDS_RST  = 8'h5;
    localparam logic [3:0] TICKS_PER_SECOND_RST = 4'h4;

    localparam logic [3:0] CUTOFF_MAX  = 4'd15;
    localparam logic [7:0] SECONDS_MAX = 8'd255;

    typedef enum logic [2:0] {
        MODE_RUN  = 3'b001,
        MODE_WAIT = 3'b010,
        MODE_DEAD = 3'b100
    } mode_t;

    typedef struct packed {
        logic [7:0] trip_level;
        logic [7:0] release_level;
        logic [3:0] retry_limit;
        logic [7:0] timeout_seconds;
        logic [3:0] ticks_per_second;
    } cfg_t;

    typedef struct packed {
        logic       load_on;
        logic       waiting;
        logic       shut_down;
        logic       led_on;
        logic [3:0] cutoff_count;
    } result_t;

endpackage

// ===== rtl/battery_low_voltage_cutoff.sv =====
// ----------------------------------------------------------------------------
// battery_low_voltage_cutoff
// low voltage load disconnect with hysteresis, retry limit and recovery timeout
// path: an accepted beat is held in the input registers, then its result is captured in the result register
// throughput: one beat per cycle while the result side is not stalled, set by the input and result registers
// reset: state returns to running with load on, counters and led cleared
// reset: configuration registers return to their default levels
// ----------------------------------------------------------------------------
`include "battery_low_voltage_cutoff_defines.svh"

module battery_low_voltage_cutoff (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bcut_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcut_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic [7:0]                       s_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_load_on,
    output logic                             m_waiting,
    output logic                             m_shut_down,
    output logic                             m_led_on,
    output logic [3:0]                       m_cutoff_count
);

    bcut_pkg::cfg_t    cfg;
    bcut_pkg::result_t res;
    bcut_pkg::result_t res_reg;

    logic       in_valid_reg;
    logic       in_func_reg;
    logic [7:0] in_sample_reg;
    logic       out_valid_reg;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    bcut_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcut_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .func    (in_func_reg),
        .sample  (in_sample_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg   <= s_func;
            in_sample_reg <= s_sample;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_load_on      = res_reg.load_on;
    assign m_waiting      = res_reg.waiting;
    assign m_shut_down    = res_reg.shut_down;
    assign m_led_on       = res_reg.led_on;
    assign m_cutoff_count = res_reg.cutoff_count;

    // checks
    `BCUT_ASSERT_NOW(a_mode_onehot, m_valid, $onehot({m_load_on, m_waiting, m_shut_down}), "mode flags not one-hot")
    `BCUT_ASSERT_NOW(a_led_dead, m_valid && m_shut_down, !m_led_on, "led lit after shutdown")
    `BCUT_ASSERT_NEXT(a_dead_sticky, m_valid && m_ready && m_shut_down, !m_valid || m_shut_down, "left shutdown")
    `BCUT_ASSERT_NEXT(a_count_mono, m_valid && m_ready, !m_valid || m_cutoff_count >= $past(m_cutoff_count), "cutoff count fell")
    `BCUT_ASSERT_NOW(a_stall_cause, !s_ready, in_valid_reg && out_valid_reg && !m_ready, "input stalled without cause")

endmodule

// ===== rtl/bcut_cfg.sv =====
// ----------------------------------------------------------------------------
// bcut_cfg
// configuration register file of the battery cutoff block
// ----------------------------------------------------------------------------
module bcut_cfg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bcut_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcut_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bcut_pkg::cfg_t                   cfg
);

    bcut_pkg::cfg_t cfg_reg;
    bcut_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                bcut_pkg::REG_TRIP_LEVEL:       cfg_next.trip_level       = cfg_data;
                bcut_pkg::REG_RELEASE_LEVEL:    cfg_next.release_level    = cfg_data;
                bcut_pkg::REG_RETRY_LIMIT:      cfg_next.retry_limit      = cfg_data[3:0];
                bcut_pkg::REG_TIMEOUT_SECONDS:  cfg_next.timeout_seconds  = cfg_data;
                bcut_pkg::REG_TICKS_PER_SECOND: cfg_next.ticks_per_second = cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trip_level       <= bcut_pkg::TRIP_LEVEL_RST;
            cfg_reg.release_level    <= bcut_pkg::RELEASE_LEVEL_RST;
            cfg_reg.retry_limit      <= bcut_pkg::RETRY_LIMIT_RST;
            cfg_reg.timeout_seconds  <= bcut_pkg::TIMEOUT_SECONDS_RST;
            cfg_reg.ticks_per_second <= bcut_pkg::TICKS_PER_SECOND_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/bcut_core.sv =====
// ----------------------------------------------------------------------------
// bcut_core
// cutoff state and its registered update for one beat
// ----------------------------------------------------------------------------
module bcut_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                func,
    input  logic [7:0]          sample,
    input  bcut_pkg::cfg_t      cfg,
    output bcut_pkg::result_t   res
);

    bcut_pkg::mode_t mode_reg, mode_next;
    logic [3:0]      cutoffs_reg, cutoffs_next;
    logic [7:0]      seconds_reg, seconds_next;
    logic [3:0]      quarter_reg, quarter_next;
    logic            led_reg, led_next;

    logic [3:0]      quarter_inc;
    logic [3:0]      cutoffs_inc;

    assign quarter_inc = quarter_reg + 4'd1;
    assign cutoffs_inc = (cutoffs_reg < bcut_pkg::CUTOFF_MAX) ? cutoffs_reg + 4'd1
                                                              : cutoffs_reg;

    always_comb begin
        mode_next    = mode_reg;
        cutoffs_next = cutoffs_reg;
        seconds_next = seconds_reg;
        quarter_next = quarter_reg;
        led_next     = led_reg;
        if (mode_reg == bcut_pkg::MODE_RUN || mode_reg == bcut_pkg::MODE_WAIT) begin
            if (func) begin
                led_next     = 1'b0;
                quarter_next = quarter_inc;
                if (quarter_inc >= cfg.ticks_per_second) begin
                    quarter_next = 4'd0;
                    if (seconds_reg < bcut_pkg::SECONDS_MAX) begin
                        seconds_next = seconds_reg + 8'd1;
                    end
                    led_next = 1'b1;
                    if (mode_reg == bcut_pkg::MODE_WAIT
                            && seconds_next > cfg.timeout_seconds) begin
                        mode_next = bcut_pkg::MODE_DEAD;
                        led_next  = 1'b0;
                    end
                end
            end else begin
                unique case (mode_reg)
                    bcut_pkg::MODE_RUN: begin
                        if (sample < cfg.trip_level) begin
                            cutoffs_next = cutoffs_inc;
                            if (cutoffs_inc >= cfg.retry_limit) begin
                                mode_next = bcut_pkg::MODE_DEAD;
                                led_next  = 1'b0;
                            end else begin
                                mode_next    = bcut_pkg::MODE_WAIT;
                                seconds_next = 8'd0;
                            end
                        end
                    end
                    default: begin
                        if (sample >= cfg.release_level) begin
                            mode_next = bcut_pkg::MODE_RUN;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= bcut_pkg::MODE_RUN;
            cutoffs_reg <= 4'd0;
            seconds_reg <= 8'd0;
            quarter_reg <= 4'd0;
            led_reg     <= 1'b0;
        end else if (step) begin
            mode_reg    <= mode_next;
            cutoffs_reg <= cutoffs_next;
            seconds_reg <= seconds_next;
            quarter_reg <= quarter_next;
            led_reg     <= led_next;
        end
    end

    always_comb begin
        res.load_on      = (mode_next == bcut_pkg::MODE_RUN);
        res.waiting      = (mode_next == bcut_pkg::MODE_WAIT);
        res.shut_down    = !(res.load_on || res.waiting);
        res.led_on       = !res.shut_down && led_next;
        res.cutoff_count = cutoffs_next;
    end

endmodule

// ===== tb/sv/battery_low_voltage_cutoff_checker.sv =====
// ----------------------------------------------------------------------------
// battery low voltage cutoff checker
// Watches the register port and both channels of the cutoff block. Every
// accepted input beat is run through a local model of the load switch, the
// retry count and the recovery timer. Each result beat is then compared
// field by field against the oldest predicted status.
// ----------------------------------------------------------------------------
module battery_low_voltage_cutoff_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [bcut_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcut_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_func,
    input  logic [7:0]                      s_sample,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_load_on,
    input  logic                            m_waiting,
    input  logic                            m_shut_down,
    input  logic                            m_led_on,
    input  logic [3:0]                      m_cutoff_count,
    output int                              fail_count,
    output int                              pending_count,
    output int                              checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    bcut_pkg::cfg_t    levels;
    bcut_pkg::mode_t   mode;
    logic [3:0]        cuts;
    logic [7:0]        secs;
    logic [3:0]        quarters;
    logic              led;
    bcut_pkg::result_t expected_status_q[$];

    function automatic bcut_pkg::result_t next_cutoff_status(input logic is_tick,
                                                             input logic [7:0] v);
        bcut_pkg::result_t r;
        logic              alive;
        if (mode == bcut_pkg::MODE_RUN || mode == bcut_pkg::MODE_WAIT) begin
            if (is_tick) begin
                led      = 1'b0;
                quarters = quarters + 4'd1;
                if (quarters >= levels.ticks_per_second) begin
                    quarters = '0;
                    if (secs != bcut_pkg::SECONDS_MAX) begin
                        secs = secs + 8'd1;
                    end
                    led = 1'b1;
                    if (mode == bcut_pkg::MODE_WAIT && secs > levels.timeout_seconds) begin
                        mode = bcut_pkg::MODE_DEAD;
                        led  = 1'b0;
                    end
                end
            end else if (mode == bcut_pkg::MODE_RUN) begin
                if (v < levels.trip_level) begin
                    if (cuts != bcut_pkg::CUTOFF_MAX) begin
                        cuts = cuts + 4'd1;
                    end
                    if (cuts >= levels.retry_limit) begin
                        mode = bcut_pkg::MODE_DEAD;
                        led  = 1'b0;
                    end else begin
                        mode = bcut_pkg::MODE_WAIT;
                        secs = '0;
                    end
                end
            end else if (v >= levels.release_level) begin
                mode = bcut_pkg::MODE_RUN;
            end
        end
        alive          = (mode == bcut_pkg::MODE_RUN || mode == bcut_pkg::MODE_WAIT);
        r.load_on      = (mode == bcut_pkg::MODE_RUN);
        r.waiting      = (mode == bcut_pkg::MODE_WAIT);
        r.shut_down    = !alive;
        r.led_on       = alive && led;
        r.cutoff_count = cuts;
        return r;
    endfunction

    always @(posedge aclk) begin
        bcut_pkg::result_t got;
        bcut_pkg::result_t want;
        if (!aresetn) begin
            levels.trip_level       = bcut_pkg::TRIP_LEVEL_RST;
            levels.release_level    = bcut_pkg::RELEASE_LEVEL_RST;
            levels.retry_limit      = bcut_pkg::RETRY_LIMIT_RST;
            levels.timeout_seconds  = bcut_pkg::TIMEOUT_SECONDS_RST;
            levels.ticks_per_second = bcut_pkg::TICKS_PER_SECOND_RST;
            mode     = bcut_pkg::MODE_RUN;
            cuts     = '0;
            secs     = '0;
            quarters = '0;
            led      = 1'b0;
            expected_status_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    bcut_pkg::REG_TRIP_LEVEL:       levels.trip_level       = cfg_data;
                    bcut_pkg::REG_RELEASE_LEVEL:    levels.release_level    = cfg_data;
                    bcut_pkg::REG_RETRY_LIMIT:      levels.retry_limit      = cfg_data[3:0];
                    bcut_pkg::REG_TIMEOUT_SECONDS:  levels.timeout_seconds  = cfg_data;
                    bcut_pkg::REG_TICKS_PER_SECOND: levels.ticks_per_second = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                expected_status_q.push_back(next_cutoff_status(s_func, s_sample));
            end
            if (m_valid && m_ready) begin
                got = '{m_load_on, m_waiting, m_shut_down, m_led_on, m_cutoff_count};
                if (expected_status_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%t: result beat with nothing expected:", $realtime);
                        $display("    load_on=%b waiting=%b shut_down=%b led_on=%b cutoffs=%0d",
                                 got.load_on, got.waiting, got.shut_down,
                                 got.led_on, got.cutoff_count);
                    end
                end else begin
                    want = expected_status_q.pop_front();
                    checked_count++;
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%t: mismatch on result %0d", $realtime, checked_count);
                            $display({"    expected load_on=%b waiting=%b shut_down=%b",
                                      " led_on=%b cutoffs=%0d"},
                                     want.load_on, want.waiting, want.shut_down,
                                     want.led_on, want.cutoff_count);
                            $display({"    actual   load_on=%b waiting=%b shut_down=%b",
                                      " led_on=%b cutoffs=%0d"},
                                     got.load_on, got.waiting, got.shut_down,
                                     got.led_on, got.cutoff_count);
                        end
                    end
                end
            end
        end
        pending_count = expected_status_q.size();
    end

endmodule

// ===== tb/sv/battery_low_voltage_cutoff_tb.sv =====
// ----------------------------------------------------------------------------
// battery low voltage cutoff testbench
// Drives voltage samples and timer ticks into the cutoff block under a series
// of trip, release, retry and timeout settings, with bursty input, a stalling
// result side and one long result hold-off. Samples are steered so that the
// load is cut and restored many times before a final forced shutdown. The
// checker module predicts and compares every result beat.
// ----------------------------------------------------------------------------
module battery_low_voltage_cutoff_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               cfg_we;
    logic [bcut_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [bcut_pkg::CFG_DATA_W-1:0]    cfg_data;
    logic                               s_valid;
    logic                               s_ready;
    logic                               s_func;
    logic [7:0]                         s_sample;
    logic                               m_valid;
    logic                               m_ready;
    logic                               m_load_on;
    logic                               m_waiting;
    logic                               m_shut_down;
    logic                               m_led_on;
    logic [3:0]                         m_cutoff_count;

    int fail_count;
    int pending_count;
    int checked_count;

    logic [7:0] trip_lvl;
    logic [7:0] release_lvl;
    logic [7:0] timeout_s;
    logic [3:0] tps;
    int         lows_left;
    logic       release_due;
    int         ticks_since_cut;
    int         burst_left;
    int         no_gap_left;
    int         beats_sent;
    int         settings_used;
    logic       hold_off_req;
    int         hold_cycles;
    int         ready_style;
    logic       final_by_timeout;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    battery_low_voltage_cutoff dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_load_on      (m_load_on),
        .m_waiting      (m_waiting),
        .m_shut_down    (m_shut_down),
        .m_led_on       (m_led_on),
        .m_cutoff_count (m_cutoff_count)
    );

    battery_low_voltage_cutoff_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_load_on      (m_load_on),
        .m_waiting      (m_waiting),
        .m_shut_down    (m_shut_down),
        .m_led_on       (m_led_on),
        .m_cutoff_count (m_cutoff_count),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    task automatic write_reg(input logic [bcut_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic apply_setting(input logic [7:0] trip, input logic [7:0] rel,
                                 input logic [3:0] retry, input logic [7:0] tmo,
                                 input logic [3:0] t);
        write_reg(bcut_pkg::REG_TRIP_LEVEL, trip);
        write_reg(bcut_pkg::REG_RELEASE_LEVEL, rel);
        write_reg(bcut_pkg::REG_RETRY_LIMIT, {4'd0, retry});
        write_reg(bcut_pkg::REG_TIMEOUT_SECONDS, tmo);
        write_reg(bcut_pkg::REG_TICKS_PER_SECOND, {4'd0, t});
        @(negedge aclk);
        cfg_we      <= 1'b0;
        trip_lvl    = trip;
        release_lvl = rel;
        timeout_s   = tmo;
        tps         = t;
        settings_used++;
    endtask

    task automatic send_beat(input logic f, input logic [7:0] v);
        @(negedge aclk);
        s_valid  <= 1'b1;
        s_func   <= f;
        s_sample <= v;
        do begin
            @(posedge aclk);
        end while (s_ready !== 1'b1);
        beats_sent++;
    endtask

    task automatic pace();
        if (no_gap_left > 0) begin
            no_gap_left--;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // samples other than planned low ones stay at or above trip, and a
    // restoring sample is forced before the recovery timer can expire
    task automatic next_random_beat(output logic f, output logic [7:0] v);
        int floor_v;
        int pick;
        floor_v = (release_lvl > trip_lvl) ? int'(release_lvl) : int'(trip_lvl);
        f = 1'b0;
        v = 8'd0;
        if (release_due && ticks_since_cut >= int'(timeout_s) * int'(tps)) begin
            v = 8'($urandom_range(floor_v, 255));
        end else if ($urandom_range(0, 4) < 2) begin
            f = 1'b1;
            v = 8'($urandom);
            if (release_due) begin
                ticks_since_cut++;
            end
        end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0 && lows_left > 0 && trip_lvl > 0) begin
                v = 8'($urandom_range(0, int'(trip_lvl) - 1));
                lows_left--;
                if (!release_due) begin
                    release_due     = 1'b1;
                    ticks_since_cut = 0;
                end
            end else if (pick < 3) begin
                case ($urandom_range(0, 2))
                    0:       pick = int'(trip_lvl);
                    1:       pick = int'(release_lvl);
                    default: pick = int'(release_lvl) - 1;
                endcase
                if (pick < int'(trip_lvl)) begin
                    pick = int'(trip_lvl);
                end
                v = 8'(pick);
            end else begin
                v = 8'($urandom_range(int'(trip_lvl), 255));
            end
        end
        if (!f && v >= release_lvl && v >= trip_lvl) begin
            release_due = 1'b0;
        end
    endtask

    task automatic run_phase(input int n, input int lows, input logic hold);
        logic       f;
        logic [7:0] v;
        lows_left = lows;
        for (int i = 0; i < n; i++) begin
            next_random_beat(f, v);
            send_beat(f, v);
            if (hold && i == 10) begin
                hold_off_req = 1'b1;
                no_gap_left  = 60;
            end
            pace();
        end
        if (release_due) begin
            send_beat(1'b0, 8'($urandom_range(
                (release_lvl > trip_lvl) ? int'(release_lvl) : int'(trip_lvl), 255)));
            release_due = 1'b0;
        end
        drain();
    endtask

    // result side: stall patterns plus one long hold-off on request
    initial begin
        m_ready     = 1'b0;
        hold_cycles = 0;
        forever begin
            ready_style = $urandom_range(0, 3);
            repeat ($urandom_range(8, 64)) begin
                @(negedge aclk);
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    hold_cycles  = 80;
                end
                if (hold_cycles > 0) begin
                    hold_cycles--;
                    m_ready <= 1'b0;
                end else begin
                    case (ready_style)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        2:       m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= ~m_ready;
                    endcase
                end
            end
        end
    end

    initial begin
        aresetn         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_func          = 1'b0;
        s_sample        = '0;
        hold_off_req    = 1'b0;
        release_due     = 1'b0;
        ticks_since_cut = 0;
        burst_left      = 0;
        no_gap_left     = 0;
        beats_sent      = 0;
        settings_used   = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // reset levels: led timing, trip edge, hysteresis edges
        send_beat(1'b0, 8'd255);  pace();
        send_beat(1'b0, 8'd166);  pace();
        send_beat(1'b1, 8'd0);    pace();
        send_beat(1'b1, 8'd0);    pace();
        send_beat(1'b1, 8'd0);    pace();
        send_beat(1'b1, 8'd0);    pace();
        send_beat(1'b0, 8'd200);  pace();
        send_beat(1'b1, 8'd0);    pace();
        send_beat(1'b0, 8'd165);  pace();
        send_beat(1'b0, 8'd0);    pace();
        send_beat(1'b0, 8'd173);  pace();
        send_beat(1'b1, 8'd255);  pace();
        send_beat(1'b0, 8'd174);  pace();
        send_beat(1'b0, 8'd174);  pace();
        drain();

        apply_setting(8'd0, 8'd255, 4'd1, 8'd254, 4'd1);
        run_phase(90, 0, 1'b0);
        apply_setting(8'd166, 8'd174, 4'd15, 8'd5, 4'd4);
        run_phase(90, 2, 1'b1);
        apply_setting(8'd255, 8'd0, 4'd15, 8'd0, 4'd15);
        run_phase(90, 2, 1'b0);
        apply_setting(8'd100, 8'd100, 4'd15, 8'd2, 4'd3);
        run_phase(90, 2, 1'b0);
        apply_setting(8'd200, 8'd50, 4'd15, 8'd1, 4'd2);
        run_phase(90, 2, 1'b0);
        apply_setting(8'($urandom_range(1, 250)), 8'($urandom), 4'd15,
                      8'($urandom_range(0, 254)), 4'($urandom_range(1, 15)));
        run_phase(90, 2, 1'b0);
        apply_setting(8'($urandom_range(1, 250)), 8'($urandom), 4'd15,
                      8'($urandom_range(0, 254)), 4'($urandom_range(1, 15)));
        run_phase(90, 1, 1'b0);

        // permanent shutdown, then beats that must be ignored
        final_by_timeout = 1'($urandom_range(0, 1));
        if (final_by_timeout) begin
            apply_setting(8'd128, 8'd200, 4'd15, 8'd0, 4'd1);
            send_beat(1'b0, 8'd0);    pace();
            send_beat(1'b0, 8'd100);  pace();
            send_beat(1'b1, 8'd0);    pace();
        end else begin
            apply_setting(8'd128, 8'd200, 4'd1, 8'd254, 4'd4);
            send_beat(1'b0, 8'd0);    pace();
            send_beat(1'b0, 8'd255);  pace();
        end
        repeat (20) begin
            send_beat(1'($urandom_range(0, 1)), 8'($urandom));
            pace();
        end
        drain();

        $display("run covered %0d beats over %0d register settings, %0d results checked",
                 beats_sent, settings_used, checked_count);
        $display("closing shutdown reached through the %s",
                 final_by_timeout ? "recovery timeout" : "retry limit");
        if (fail_count + pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout waiting for the block");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
